// File: sv/brsc_pkg.sv
// Package for the bitmap range set/clear block: sizes, codes and the control program.
package brsc_pkg;

  // Store geometry
  localparam int MAP_BYTES = 512;
  localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BIT_W     = 12;
  localparam int BYTE_W    = BIT_W - 3;
  localparam int IDX_W     = 9;
  localparam int CUR_W     = (ADDR_W > BYTE_W) ? ADDR_W : BYTE_W;

  // Operation codes carried on s_tuser
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Program steps
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_DISP  = 3'd2,
    ST_RDB   = 3'd3,
    ST_CAPT  = 3'd4,
    ST_RD    = 3'd5,
    ST_WR    = 3'd6,
    ST_DONE  = 3'd7
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_FIRE,
    C_RANGE_GO,
    C_MORE
  } cond_t;

  // Datapath actions
  typedef enum logic [2:0] {
    A_CLR_WR,
    A_LOAD,
    A_RD_ADDR,
    A_CAPT,
    A_RD_CUR,
    A_WR_MOD,
    A_DONE,
    A_NONE
  } act_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{act: A_NONE, cond: C_NONE, target: ST_IDLE};
    unique case (step)
      ST_CLEAR: w = '{act: A_CLR_WR,  cond: C_MORE,     target: ST_CLEAR};
      ST_IDLE:  w = '{act: A_LOAD,    cond: C_NO_FIRE,  target: ST_IDLE};
      ST_DISP:  w = '{act: A_NONE,    cond: C_RANGE_GO, target: ST_RD};
      ST_RDB:   w = '{act: A_RD_ADDR, cond: C_NONE,     target: ST_IDLE};
      ST_CAPT:  w = '{act: A_CAPT,    cond: C_ALWAYS,   target: ST_DONE};
      ST_RD:    w = '{act: A_RD_CUR,  cond: C_NONE,     target: ST_IDLE};
      ST_WR:    w = '{act: A_WR_MOD,  cond: C_MORE,     target: ST_RD};
      ST_DONE:  w = '{act: A_DONE,    cond: C_ALWAYS,   target: ST_IDLE};
      default:  w = '{act: A_NONE,    cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: sv/brsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bitmap_range_set_clear.sv
// Top level of the bitmap range set/clear block: control program and datapath.
//
// A bitmap of MAP_BYTES bytes (bit b sits in byte b/8 at position b%8).
// Input channel s_*: one item is one operation; s_tuser holds the operation
// (set range, clear range, read byte), s_tdata the bit range and byte index.
// Output channel m_*: exactly one result item per input item, m_tdata is the
// byte read (zero for set and clear), m_tuser flags an empty range.
// A small control program steps a plain datapath around one RAM port pair.
// Per item the program steps: a read, an unused code or an empty range goes
// through dispatch, a read of the indexed byte, a capture of the read data and
// the result step; a set or clear goes through dispatch, then a read then a
// write per byte (the write waits on the RAM's registered read), then the
// result step.
// After reset the block runs a clearing pass over all MAP_BYTES bytes with
// s_tready low, then waits for items.
// The output register lets the next item be taken while a result waits; if
// m_tready stays low, the program holds at its final step until the waiting
// result is taken, and s_tready stays low meanwhile.
module bitmap_range_set_clear
  import brsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // s_tdata: low_bit [11:0], high_bit [23:12], read_byte_index [32:24], zero fill
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: op [1:0]
  input  logic [1:0]  s_tuser,
  // m_tdata: read_data [7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  // m_tuser: empty_range [0]
  output logic        m_tuser
);

  step_t upc, upc_next;
  ctrl_t cw;

  logic [1:0]        op_reg;
  logic [BIT_W-1:0]  low_reg;
  logic [BIT_W-1:0]  high_reg;
  logic [IDX_W-1:0]  idx_reg;
  logic [CUR_W-1:0]  cur;
  logic [CUR_W-1:0]  first;
  logic [CUR_W-1:0]  last;
  logic [7:0]        res_data;
  logic              res_empty;

  logic              s_fire;
  logic              out_busy;
  logic              is_range;
  logic              range_go;
  logic              more;
  logic              take_jump;
  logic              cur_in_map;
  logic              idx_in_map;
  logic [7:0]        lo_mask;
  logic [7:0]        hi_mask;
  logic [7:0]        mask;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign cw       = ucode(upc);
  assign s_tready = (cw.act == A_LOAD);
  assign s_fire   = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  // Decode the held operation
  assign is_range   = (op_reg == OP_SET) || (op_reg == OP_CLEAR);
  assign range_go   = is_range && (high_reg >= low_reg);
  assign more       = (cur != last);
  assign cur_in_map = (32'(cur) < MAP_BYTES);
  assign idx_in_map = (32'(idx_reg) < MAP_BYTES);

  // Edge masks for the first and last byte of the range
  assign lo_mask = 8'hFF << low_reg[2:0];
  assign hi_mask = 8'hFF >> (3'd7 - high_reg[2:0]);

  always_comb begin
    mask = 8'hFF;
    if (cur == first) begin
      mask = mask & lo_mask;
    end
    if (cur == last) begin
      mask = mask & hi_mask;
    end
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (cw.cond)
      C_NONE:     take_jump = 1'b0;
      C_ALWAYS:   take_jump = 1'b1;
      C_NO_FIRE:  take_jump = !s_fire;
      C_RANGE_GO: take_jump = range_go;
      C_MORE:     take_jump = more;
      default:    take_jump = 1'b0;
    endcase
  end

  // Step counter: hold on a blocked result, else jump or advance
  always_comb begin
    if (cw.act == A_DONE && out_busy) begin
      upc_next = upc;
    end else if (take_jump) begin
      upc_next = cw.target;
    end else begin
      upc_next = step_t'(upc + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  // RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    unique case (cw.act)
      A_CLR_WR: begin
        ram_we    = cur_in_map;
        ram_wdata = 8'h00;
      end
      A_WR_MOD: begin
        ram_we    = cur_in_map;
        ram_wdata = (op_reg == OP_SET) ? (ram_rdata | mask) : (ram_rdata & ~mask);
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = 8'h00;
      end
    endcase
  end

  assign ram_waddr = ADDR_W'(cur);
  assign ram_raddr = (cw.act == A_RD_ADDR) ? ADDR_W'(idx_reg) : ADDR_W'(cur);

  brsc_ram #(
    .WIDTH(8),
    .DEPTH(MAP_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Byte pointer and range bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= '0;
      first <= '0;
      last  <= CUR_W'(MAP_BYTES - 1);
    end else begin
      unique case (cw.act)
        A_LOAD: begin
          if (s_fire) begin
            cur   <= CUR_W'(s_tdata[11:3]);
            first <= CUR_W'(s_tdata[11:3]);
            last  <= CUR_W'(s_tdata[23:15]);
          end
        end
        A_CLR_WR, A_WR_MOD: begin
          cur <= cur + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the item's fields and build the result
  always_ff @(posedge clk) begin
    if (cw.act == A_LOAD && s_fire) begin
      op_reg   <= s_tuser;
      low_reg  <= s_tdata[11:0];
      high_reg <= s_tdata[23:12];
      idx_reg  <= s_tdata[32:24];
      res_data <= 8'h00;
      res_empty <= ((s_tuser == OP_SET) || (s_tuser == OP_CLEAR))
                   && (s_tdata[23:12] < s_tdata[11:0]);
    end else if (cw.act == A_CAPT) begin
      res_data <= (op_reg == OP_READ && idx_in_map) ? ram_rdata : 8'h00;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cw.act == A_DONE && !out_busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.act == A_DONE && !out_busy) begin
      m_tdata <= res_data;
      m_tuser <= res_empty;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the bitmap range set/clear block.
module testbench;
  import brsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM    = 1000;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;

  // One operation as driven on the input channel
  typedef struct {
    logic [1:0]  op;
    logic [11:0] low_bit;
    logic [11:0] high_bit;
    logic [8:0]  byte_idx;
    int          gap;
  } bitmap_op_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       empty_range;
  } op_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;

  bitmap_op_t  ops_to_send[$];
  op_outcome_t outcomes_due[$];
  logic [7:0]  bitmap_shadow [MAP_BYTES];

  int ops_total;
  int outcomes_seen = 0;
  int error_count = 0;
  int gap_wait = 0;
  int stall_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int last_range_byte = 0;

  bitmap_range_set_clear DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow bitmap and return the result it produces
  function automatic op_outcome_t bitmap_apply(input bitmap_op_t o);
    op_outcome_t r;
    int          first_byte;
    int          last_byte;
    logic [7:0]  mask;
    r = '0;
    first_byte = int'(o.low_bit >> 3);
    last_byte  = int'(o.high_bit >> 3);
    if (o.op == OP_SET || o.op == OP_CLEAR) begin
      if (o.high_bit < o.low_bit) begin
        r.empty_range = 1'b1;
      end else begin
        for (int b = first_byte; b <= last_byte; b++) begin
          mask = 8'hFF;
          if (b == first_byte) mask &= 8'hFF << o.low_bit[2:0];
          if (b == last_byte) mask &= 8'hFF >> (3'd7 - o.high_bit[2:0]);
          if (b < MAP_BYTES) begin
            if (o.op == OP_SET) bitmap_shadow[b] = bitmap_shadow[b] | mask;
            else bitmap_shadow[b] = bitmap_shadow[b] & ~mask;
          end
        end
      end
    end else if (o.op == OP_READ) begin
      if (int'(o.byte_idx) < MAP_BYTES) r.read_data = bitmap_shadow[o.byte_idx];
    end
    return r;
  endfunction

  function automatic bitmap_op_t make_op(input logic [1:0] op, input int low, input int high,
                                         input int idx);
    bitmap_op_t o;
    o.op       = op;
    o.low_bit  = low[11:0];
    o.high_bit = high[11:0];
    o.byte_idx = idx[8:0];
    o.gap      = $urandom_range(0, 13);
    return o;
  endfunction

  // Random operation: mostly short ranges, some empty, a few spanning most of the map
  function automatic bitmap_op_t random_op(input bit quiet);
    bitmap_op_t o;
    int         pick;
    int         low;
    int         high;
    int         idx;
    pick = $urandom_range(0, 99);
    low  = $urandom_range(0, 4095);
    high = $urandom_range(0, 4095);
    idx  = $urandom_range(0, 511);
    if (pick < 60) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        low  = $urandom_range(1, 4095);
        high = $urandom_range(0, low - 1);
      end else if (pick < 10) begin
        low  = $urandom_range(0, 300);
        high = $urandom_range(3800, 4095);
      end else begin
        high = low + $urandom_range(0, 47);
        if (high > 4095) high = 4095;
      end
      last_range_byte = low >> 3;
      o = make_op(($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_SET, low, high, idx);
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) != 0) idx = last_range_byte + $urandom_range(0, 5);
      if (idx > 511) idx = 511;
      o = make_op(OP_READ, low, high, idx);
    end else begin
      o = make_op(OP_UNUSED, low, high, idx);
    end
    if (quiet) o.gap = 0;
    return o;
  endfunction

  // Build the stimulus, release reset, wait for every result, then report
  initial begin
    bit quiet;
    ops_to_send.push_back(make_op(OP_READ, 4095, 0, 0));
    ops_to_send.push_back(make_op(OP_SET, 0, 4095, 0));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 0));
    ops_to_send.push_back(make_op(OP_READ, 4095, 4095, 511));
    ops_to_send.push_back(make_op(OP_CLEAR, 8, 4087, 511));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 1));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 510));
    ops_to_send.push_back(make_op(OP_CLEAR, 0, 7, 0));
    ops_to_send.push_back(make_op(OP_SET, 3, 5, 511));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 0));
    ops_to_send.push_back(make_op(OP_SET, 13, 30, 0));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 1));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 2));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 3));
    ops_to_send.push_back(make_op(OP_CLEAR, 14, 28, 0));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 2));
    ops_to_send.push_back(make_op(OP_SET, 100, 99, 12));
    ops_to_send.push_back(make_op(OP_CLEAR, 4095, 0, 12));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 12));
    ops_to_send.push_back(make_op(OP_UNUSED, 4095, 4095, 511));
    ops_to_send.push_back(make_op(OP_CLEAR, 4095, 4095, 0));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 511));
    ops_to_send.push_back(make_op(OP_SET, 0, 0, 0));
    ops_to_send.push_back(make_op(OP_READ, 0, 0, 0));
    // Quiet chunks drop the sender gaps; the receiver hold-off window stays gapless
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = ((i / 100) % 4 == 1) || (i >= HOLD_AT - 40 && i < HOLD_AT + 80);
      ops_to_send.push_back(random_op(quiet));
    end
    ops_total = ops_to_send.size();
    for (int b = 0; b < MAP_BYTES; b++) bitmap_shadow[b] = 8'h00;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (outcomes_seen < ops_total) @(posedge clk);
    repeat (20) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Drive items: predict on accept, hold while stalled, wait out each item's gap
  always @(posedge clk) begin : drive_ops
    bitmap_op_t took;
    bitmap_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        took.op       = s_tuser;
        took.low_bit  = s_tdata[11:0];
        took.high_bit = s_tdata[23:12];
        took.byte_idx = s_tdata[32:24];
        took.gap      = 0;
        outcomes_due.push_back(bitmap_apply(took));
      end
      if (!(s_tvalid && !s_tready)) begin
        if (ops_to_send.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (gap_wait < ops_to_send[0].gap) begin
          gap_wait++;
          s_tvalid <= 1'b0;
        end else begin
          nxt = ops_to_send.pop_front();
          s_tdata  <= {7'b0, nxt.byte_idx, nxt.high_bit, nxt.low_bit};
          s_tuser  <= nxt.op;
          s_tvalid <= 1'b1;
          gap_wait = 0;
        end
      end
    end
  end

  // Check results and pace m_tready, with one long hold-off to back up the block
  always @(posedge clk) begin : check_results
    op_outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual data=%h empty=%b",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          want = outcomes_due.pop_front();
          if (m_tdata !== want.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want.read_data, m_tdata);
            error_count++;
          end
          if (m_tuser !== want.empty_range) begin
            $display("%0t: empty_range mismatch: expected %b, actual %b",
                     $time, want.empty_range, m_tuser);
            error_count++;
          end
        end
        outcomes_seen++;
        if (outcomes_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        else if ((outcomes_seen / 100) % 4 == 3) stall_left = 0;
        else stall_left = $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // End the run if neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
